// ----- rtl/core/torus_point_zbuffer_shader_top_assert.svh -----
// Assertion macros for the torus point z-buffer shader.
// Included by the checker; needs a clock named aclk and a reset named aresetn.
`ifndef TORUS_POINT_ZBUFFER_SHADER_TOP_ASSERT_SVH
`define TORUS_POINT_ZBUFFER_SHADER_TOP_ASSERT_SVH

// same-cycle implication
`define TPZS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPZS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tpzs_pkg.sv -----
// Shared types, constants and fixed-point helpers for the torus shader.
// No dependencies; imported by every module of the block except tpzs_ram.
package tpzs_pkg;

    localparam int TRIG_W     = 16;
    localparam int ACC_W      = 24;
    localparam int PROD_W     = 2 * ACC_W;
    localparam int DEPTH_W    = 16;
    localparam int CODE_W     = 4;
    localparam int GLYPH_W    = 7;
    localparam int CELL_IDX_W = 14;
    localparam int DIV_Q_W    = 31;
    localparam int CFG_IDX_W  = 3;

    localparam logic [GLYPH_W-1:0] BLANK_CHAR = 7'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_A = 3'd0,
        CFG_SIN_A = 3'd1,
        CFG_COS_B = 3'd2,
        CFG_SIN_B = 3'd3,
        CFG_SCALE = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        MODE_PLOT = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_a;
        logic signed [TRIG_W-1:0] sin_a;
        logic signed [TRIG_W-1:0] cos_b;
        logic signed [TRIG_W-1:0] sin_b;
        logic        [TRIG_W-1:0] scale;
    } cfg_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [TRIG_W-1:0] cos_theta;
        logic signed [TRIG_W-1:0] sin_theta;
        logic signed [TRIG_W-1:0] cos_phi;
        logic signed [TRIG_W-1:0] sin_phi;
        logic                     in_range;
        logic [CELL_IDX_W-1:0]    cell_idx;
    } item_t;

    typedef struct packed {
        logic clear_done;
    } back_status_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_MATH,
        B_DIV_START,
        B_DIV_WAIT,
        B_PROD,
        B_PXLO,
        B_PXHI,
        B_PYLO,
        B_PYHI,
        B_BOUND,
        B_MEM_RD,
        B_MEM_CHK,
        B_DONE
    } back_state_t;

    typedef enum logic [4:0] {
        ST_CB_CP,
        ST_SA_SB,
        ST_X_SP,
        ST_X_CIRC,
        ST_CA_SB,
        ST_X_ST,
        ST_CP_SB,
        ST_CB_SA,
        ST_Y_SP,
        ST_Y_CIRC,
        ST_CA_CB,
        ST_Y_ST,
        ST_CIRC_SP,
        ST_Z_CA,
        ST_Z_SA,
        ST_CP_CT,
        ST_L_SB,
        ST_CA_CT,
        ST_L_SP,
        ST_CT_SA,
        ST_T_SP,
        ST_CA_ST,
        ST_L_CB
    } step_t;

    function automatic logic signed [ACC_W-1:0] sx24(input logic signed [TRIG_W-1:0] v);
        return ACC_W'(v);
    endfunction

    // Q2.14 product scaled back, truncated toward zero
    function automatic logic signed [ACC_W-1:0] qm(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        r = p + (p[PROD_W-1] ? 48'sd16383 : 48'sd0);
        return r[37:14];
    endfunction

    function automatic logic [GLYPH_W-1:0] shade_char(input logic [CODE_W-1:0] idx);
        logic [GLYPH_W-1:0] c;
        unique case (idx)
            4'd0:    c = 7'h2E;
            4'd1:    c = 7'h2C;
            4'd2:    c = 7'h2D;
            4'd3:    c = 7'h7E;
            4'd4:    c = 7'h3A;
            4'd5:    c = 7'h3B;
            4'd6:    c = 7'h3D;
            4'd7:    c = 7'h21;
            4'd8:    c = 7'h2A;
            4'd9:    c = 7'h23;
            4'd10:   c = 7'h24;
            4'd11:   c = 7'h40;
            default: c = BLANK_CHAR;
        endcase
        return c;
    endfunction

    function automatic logic [GLYPH_W-1:0] char_of(input logic [CODE_W-1:0] code);
        logic [GLYPH_W-1:0] c;
        if (code == 4'd0 || code > 4'd12) begin
            c = BLANK_CHAR;
        end else begin
            c = shade_char(code - 4'd1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/tpzs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpzs_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2500
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/core/tpzs_div.sv -----
// Restoring divider, one quotient bit per cycle: 2^30 / divisor.
// Depends on tpzs_pkg for widths.
module tpzs_div import tpzs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ACC_W-1:0]   divisor,
    output logic               done,
    output logic [DIV_Q_W-1:0] quotient
);
    localparam logic [DIV_Q_W-1:0] DIVIDEND = DIV_Q_W'(1) << (DIV_Q_W - 1);

    logic               busy_reg, done_reg;
    logic [4:0]         cnt_reg;
    logic [ACC_W:0]     rem_reg;
    logic [DIV_Q_W-1:0] quo_reg;
    logic [ACC_W-1:0]   dvs_reg;
    logic [ACC_W:0]     trial;
    logic               ge;

    assign trial = {rem_reg[ACC_W-1:0], quo_reg[DIV_Q_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DIV_Q_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= DIVIDEND;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? (trial - {1'b0, dvs_reg}) : trial;
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- rtl/core/tpzs_front.sv -----
// Front end: accepts transactions, classifies read requests, queues items.
// Depends on tpzs_pkg.
module tpzs_front import tpzs_pkg::*; #(
    parameter int SCREEN_WIDTH  = 50,
    parameter int SCREEN_HEIGHT = 50
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic signed [TRIG_W-1:0] s_cos_theta,
    input  logic signed [TRIG_W-1:0] s_sin_theta,
    input  logic signed [TRIG_W-1:0] s_cos_phi,
    input  logic signed [TRIG_W-1:0] s_sin_phi,
    input  logic [5:0]               s_cell_row,
    input  logic [5:0]               s_cell_col,
    input  back_status_t             status,
    output logic                     q_valid,
    output item_t                    q_item,
    input  logic                     q_pop
);
    item_t      q_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    item_t      in_item;
    logic       push;

    always_comb begin
        in_item.mode      = mode_t'(s_mode);
        in_item.cos_theta = s_cos_theta;
        in_item.sin_theta = s_sin_theta;
        in_item.cos_phi   = s_cos_phi;
        in_item.sin_phi   = s_sin_phi;
        in_item.in_range  = (32'(s_cell_row) < SCREEN_HEIGHT) && (32'(s_cell_col) < SCREEN_WIDTH);
        in_item.cell_idx  = CELL_IDX_W'(32'(s_cell_row) * SCREEN_WIDTH + 32'(s_cell_col));
    end

    assign s_ready = status.clear_done && (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// ----- rtl/core/tpzs_back.sv -----
// Back end: microcoded multiply sequence, divider, projection and z-buffer store.
// Depends on tpzs_pkg, tpzs_div and tpzs_ram.
module tpzs_back import tpzs_pkg::*; #(
    parameter int SCREEN_WIDTH  = 50,
    parameter int SCREEN_HEIGHT = 50
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output back_status_t       status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [GLYPH_W-1:0] m_glyph,
    output logic               m_drawn,
    output logic               m_off_screen
);
    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CW    = $clog2(CELLS);
    localparam int MEM_W = DEPTH_W + CODE_W;
    localparam logic signed [63:0] X_BIAS = 64'(SCREEN_WIDTH / 2) <<< 38;
    localparam logic signed [63:0] X_LIM  = 64'(SCREEN_WIDTH) <<< 38;
    localparam logic signed [63:0] X_NEG  = -(64'sd1 <<< 38);
    localparam logic signed [63:0] Y_BIAS = 64'(SCREEN_HEIGHT / 2) <<< 39;
    localparam logic signed [63:0] Y_LIM  = 64'(SCREEN_HEIGHT) <<< 39;
    localparam logic signed [63:0] Y_NEG  = -(64'sd1 <<< 39);
    localparam logic signed [ACC_W-1:0] Z_BIAS   = 24'sd81920;
    localparam logic signed [ACC_W-1:0] CIRC_OFS = 24'sd32768;
    localparam logic signed [ACC_W-1:0] LUM_TOP  = 24'sd22528;

    back_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    logic [CW-1:0] clr_reg;

    mode_t                    mode_reg;
    logic                     in_range_reg;
    logic signed [ACC_W-1:0]  ct_reg, st_reg, cp_reg, sp_reg, circ_reg, t_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg, acc_z_reg, acc_l_reg;
    logic [DEPTH_W-1:0]       ooz_reg;
    logic [31:0]              p_reg;
    logic signed [PROD_W-1:0] lo_reg;
    logic signed [63:0]       numx_reg, numy_reg;
    logic [CW-1:0]            cell_reg;
    logic [GLYPH_W-1:0]       res_glyph_reg;
    logic                     res_drawn_reg, res_off_reg;
    logic                     m_valid_reg, m_drawn_reg, m_off_reg;
    logic [GLYPH_W-1:0]       m_glyph_reg;

    logic signed [ACC_W-1:0]  ca, sa, cb, sb, mul_a, mul_b, q;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start, div_done;
    logic [DIV_Q_W-1:0]       div_q;
    logic                     ram_we, ram_re, out_load;
    logic [CW-1:0]            ram_waddr;
    logic [MEM_W-1:0]         ram_wdata, ram_rdata;
    logic                     z_pos, on_screen, lum_pos, nearer;
    logic [6:0]               xp, yp;
    logic [CODE_W-1:0]        shade_idx;

    assign ca = sx24(cfg.cos_a);
    assign sa = sx24(cfg.sin_a);
    assign cb = sx24(cfg.cos_b);
    assign sb = sx24(cfg.sin_b);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            B_MATH: begin
                unique case (step_reg)
                    ST_CB_CP:   begin mul_a = cb;       mul_b = cp_reg;    end
                    ST_SA_SB:   begin mul_a = sa;       mul_b = sb;        end
                    ST_X_SP:    begin mul_a = t_reg;    mul_b = sp_reg;    end
                    ST_X_CIRC:  begin mul_a = circ_reg; mul_b = acc_x_reg; end
                    ST_CA_SB:   begin mul_a = ca;       mul_b = sb;        end
                    ST_X_ST:    begin mul_a = t_reg;    mul_b = st_reg;    end
                    ST_CP_SB:   begin mul_a = cp_reg;   mul_b = sb;        end
                    ST_CB_SA:   begin mul_a = cb;       mul_b = sa;        end
                    ST_Y_SP:    begin mul_a = t_reg;    mul_b = sp_reg;    end
                    ST_Y_CIRC:  begin mul_a = circ_reg; mul_b = acc_y_reg; end
                    ST_CA_CB:   begin mul_a = ca;       mul_b = cb;        end
                    ST_Y_ST:    begin mul_a = t_reg;    mul_b = st_reg;    end
                    ST_CIRC_SP: begin mul_a = circ_reg; mul_b = sp_reg;    end
                    ST_Z_CA:    begin mul_a = ca;       mul_b = t_reg;     end
                    ST_Z_SA:    begin mul_a = sa;       mul_b = st_reg;    end
                    ST_CP_CT:   begin mul_a = cp_reg;   mul_b = ct_reg;    end
                    ST_L_SB:    begin mul_a = t_reg;    mul_b = sb;        end
                    ST_CA_CT:   begin mul_a = ca;       mul_b = ct_reg;    end
                    ST_L_SP:    begin mul_a = t_reg;    mul_b = sp_reg;    end
                    ST_CT_SA:   begin mul_a = ct_reg;   mul_b = sa;        end
                    ST_T_SP:    begin mul_a = t_reg;    mul_b = sp_reg;    end
                    ST_CA_ST:   begin mul_a = ca;       mul_b = st_reg;    end
                    ST_L_CB:    begin mul_a = cb;       mul_b = t_reg;     end
                    default:    begin mul_a = '0;       mul_b = '0;        end
                endcase
            end
            B_PROD: begin
                mul_a = {8'd0, cfg.scale};
                mul_b = {8'd0, ooz_reg};
            end
            B_PXLO: begin
                mul_a = {8'd0, p_reg[15:0]};
                mul_b = acc_x_reg;
            end
            B_PXHI: begin
                mul_a = {8'd0, p_reg[31:16]};
                mul_b = acc_x_reg;
            end
            B_PYLO: begin
                mul_a = {8'd0, p_reg[15:0]};
                mul_b = acc_y_reg;
            end
            B_PYHI: begin
                mul_a = {8'd0, p_reg[31:16]};
                mul_b = acc_y_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign q    = qm(prod);

    assign z_pos     = !acc_z_reg[ACC_W-1] && (acc_z_reg != '0);
    assign on_screen = (numx_reg > X_NEG) && (numx_reg < X_LIM)
                    && (numy_reg > Y_NEG) && (numy_reg < Y_LIM);
    assign xp        = numx_reg[63] ? 7'd0 : numx_reg[44:38];
    assign yp        = numy_reg[63] ? 7'd0 : numy_reg[45:39];
    assign lum_pos   = !acc_l_reg[ACC_W-1] && (acc_l_reg != '0);
    assign shade_idx = (acc_l_reg >= LUM_TOP) ? 4'd11 : acc_l_reg[14:11];
    assign nearer    = ooz_reg > ram_rdata[MEM_W-1:CODE_W];

    tpzs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (acc_z_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    tpzs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cell_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            step_reg    <= ST_CB_CP;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == B_CLEAR) begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = cell_reg;
        ram_wdata  = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == CW'(CELLS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.mode == MODE_READ) begin
                        state_next = q_item.in_range ? B_MEM_RD : B_DONE;
                    end else begin
                        state_next = B_MATH;
                        step_next  = ST_CB_CP;
                    end
                end
            end
            B_MATH: begin
                if (step_reg == ST_L_CB) begin
                    state_next = B_DIV_START;
                end else begin
                    step_next = step_t'(5'(step_reg) + 5'd1);
                end
            end
            B_DIV_START: begin
                div_start  = z_pos;
                state_next = z_pos ? B_DIV_WAIT : B_DONE;
            end
            B_DIV_WAIT: begin
                if (div_done) begin
                    state_next = B_PROD;
                end
            end
            B_PROD:  state_next = B_PXLO;
            B_PXLO:  state_next = B_PXHI;
            B_PXHI:  state_next = B_PYLO;
            B_PYLO:  state_next = B_PYHI;
            B_PYHI:  state_next = B_BOUND;
            B_BOUND: state_next = on_screen ? B_MEM_RD : B_DONE;
            B_MEM_RD: begin
                ram_re     = 1'b1;
                state_next = B_MEM_CHK;
            end
            B_MEM_CHK: begin
                if (mode_reg == MODE_READ) begin
                    ram_we = 1'b1;
                end else if (lum_pos && nearer) begin
                    ram_we    = 1'b1;
                    ram_wdata = {ooz_reg, shade_idx + 4'd1};
                end
                state_next = B_DONE;
            end
            B_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                mode_reg      <= q_item.mode;
                in_range_reg  <= q_item.in_range;
                ct_reg        <= sx24(q_item.cos_theta);
                st_reg        <= sx24(q_item.sin_theta);
                cp_reg        <= sx24(q_item.cos_phi);
                sp_reg        <= sx24(q_item.sin_phi);
                circ_reg      <= CIRC_OFS + sx24(q_item.cos_theta);
                cell_reg      <= q_item.cell_idx[CW-1:0];
                res_glyph_reg <= BLANK_CHAR;
                res_drawn_reg <= 1'b0;
                res_off_reg   <= 1'b0;
            end
            B_MATH: begin
                unique case (step_reg)
                    ST_CB_CP:   acc_x_reg <= q;
                    ST_X_SP:    acc_x_reg <= acc_x_reg + q;
                    ST_X_CIRC:  acc_x_reg <= q;
                    ST_X_ST:    acc_x_reg <= acc_x_reg - q;
                    ST_CP_SB:   acc_y_reg <= q;
                    ST_Y_SP:    acc_y_reg <= acc_y_reg - q;
                    ST_Y_CIRC:  acc_y_reg <= q;
                    ST_Y_ST:    acc_y_reg <= acc_y_reg + q;
                    ST_Z_CA:    acc_z_reg <= Z_BIAS + q;
                    ST_Z_SA: begin
                        acc_z_reg <= acc_z_reg + q;
                        acc_l_reg <= -q;
                    end
                    ST_L_SB:    acc_l_reg <= acc_l_reg + q;
                    ST_L_SP:    acc_l_reg <= acc_l_reg - q;
                    ST_CA_ST:   t_reg     <= q - t_reg;
                    ST_L_CB:    acc_l_reg <= acc_l_reg + q;
                    default:    t_reg     <= q;
                endcase
            end
            B_DIV_START: begin
                if (!z_pos) begin
                    res_off_reg <= 1'b1;
                end
            end
            B_DIV_WAIT: begin
                ooz_reg <= (div_q[DIV_Q_W-1:DEPTH_W] != '0) ? '1 : div_q[DEPTH_W-1:0];
            end
            B_PROD: p_reg <= prod[31:0];
            B_PXLO: lo_reg <= prod;
            B_PXHI: numx_reg <= X_BIAS + (64'(prod) <<< 16) + 64'(lo_reg);
            B_PYLO: lo_reg <= prod;
            B_PYHI: numy_reg <= Y_BIAS - ((64'(prod) <<< 16) + 64'(lo_reg));
            B_BOUND: begin
                res_off_reg <= !on_screen;
                cell_reg    <= CW'(32'(yp) * SCREEN_WIDTH + 32'(xp));
            end
            B_MEM_CHK: begin
                if (mode_reg == MODE_READ) begin
                    res_glyph_reg <= in_range_reg ? char_of(ram_rdata[CODE_W-1:0]) : BLANK_CHAR;
                end else if (lum_pos && nearer) begin
                    res_glyph_reg <= shade_char(shade_idx);
                    res_drawn_reg <= 1'b1;
                end
            end
            B_DONE: begin
                if (out_load) begin
                    m_glyph_reg <= res_glyph_reg;
                    m_drawn_reg <= res_drawn_reg;
                    m_off_reg   <= res_off_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign status.clear_done = state_reg != B_CLEAR;
    assign m_valid      = m_valid_reg;
    assign m_glyph      = m_glyph_reg;
    assign m_drawn      = m_drawn_reg;
    assign m_off_screen = m_off_reg;
endmodule

// ----- rtl/core/torus_point_zbuffer_shader_top.sv -----
// Plot transaction: queue pop, 23-step multiply sequence, divide, projection and bound
// checks, then store read and write (skipped off screen); read: pop, store read, write.
// The back end handles one transaction at a time.
// A two-entry queue and an output register keep input and output decoupled.
// Reset: synchronous, active low; config returns to defaults, then a clearing pass
// over all SCREEN_WIDTH*SCREEN_HEIGHT cells (2500 by default) runs before s_ready rises.
module torus_point_zbuffer_shader_top import tpzs_pkg::*; #(
    parameter int SCREEN_WIDTH  = 50,
    parameter int SCREEN_HEIGHT = 50
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [TRIG_W-1:0]        cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic signed [TRIG_W-1:0] s_cos_theta,
    input  logic signed [TRIG_W-1:0] s_sin_theta,
    input  logic signed [TRIG_W-1:0] s_cos_phi,
    input  logic signed [TRIG_W-1:0] s_sin_phi,
    input  logic [5:0]               s_cell_row,
    input  logic [5:0]               s_cell_col,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [GLYPH_W-1:0]       m_glyph,
    output logic                     m_drawn,
    output logic                     m_off_screen
);
    cfg_t         cfg_reg;
    back_status_t status;
    item_t        q_item;
    logic         q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_a <= 16'sd16384;
            cfg_reg.sin_a <= 16'sd0;
            cfg_reg.cos_b <= 16'sd16384;
            cfg_reg.sin_b <= 16'sd0;
            cfg_reg.scale <= 16'd8000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_COS_A: cfg_reg.cos_a <= cfg_data;
                CFG_SIN_A: cfg_reg.sin_a <= cfg_data;
                CFG_COS_B: cfg_reg.cos_b <= cfg_data;
                CFG_SIN_B: cfg_reg.sin_b <= cfg_data;
                CFG_SCALE: cfg_reg.scale <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    tpzs_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_cos_theta (s_cos_theta),
        .s_sin_theta (s_sin_theta),
        .s_cos_phi   (s_cos_phi),
        .s_sin_phi   (s_sin_phi),
        .s_cell_row  (s_cell_row),
        .s_cell_col  (s_cell_col),
        .status      (status),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    tpzs_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_glyph      (m_glyph),
        .m_drawn      (m_drawn),
        .m_off_screen (m_off_screen)
    );
endmodule

// ----- rtl/core/tpzs_checker.sv -----
// Port-level checks on the shader result channel, bound to the top level.
// Depends on tpzs_pkg and torus_point_zbuffer_shader_top_assert.svh.
`include "torus_point_zbuffer_shader_top_assert.svh"

module tpzs_checker import tpzs_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [GLYPH_W-1:0] m_glyph,
    input logic               m_drawn,
    input logic               m_off_screen
);
    `TPZS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_glyph) && $stable(m_drawn) && $stable(m_off_screen), "result changed while stalled")
    `TPZS_ASSERT_NOW(a_flags_excl, m_valid, !(m_drawn && m_off_screen), "drawn and off_screen both set")
    `TPZS_ASSERT_NOW(a_drawn_glyph, m_valid && m_drawn, m_glyph != BLANK_CHAR, "drawn sample with blank glyph")
    `TPZS_ASSERT_NOW(a_off_blank, m_valid && m_off_screen, m_glyph == BLANK_CHAR, "dropped sample with a glyph")
endmodule

bind torus_point_zbuffer_shader_top tpzs_checker u_tpzs_checker (.*);

// ----- tb/torus_point_zbuffer_shader_top_tb.sv -----
// Testbench for the torus point z-buffer shader: directed and random plot and read
// transactions, predicted in-bench and checked in order. Depends on tpzs_pkg.
module torus_point_zbuffer_shader_top_tb;
    import tpzs_pkg::*;

    localparam int W = 50;
    localparam int H = 50;
    localparam longint LIMIT = 2000000;

    typedef struct {
        logic [GLYPH_W-1:0] glyph;
        logic drawn;
        logic off;
    } shade_res_t;

    class shade_board;
        logic signed [15:0] ca, sa, cb, sb;
        logic [15:0] k1;
        logic [15:0] zdep [W*H];
        logic [3:0] code [W*H];
        shade_res_t pending [$];
        int errors;
        int checked;

        function new();
            ca = 16384; sa = 0; cb = 16384; sb = 0; k1 = 8000;
            foreach (zdep[i]) begin
                zdep[i] = 0;
                code[i] = 0;
            end
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_COS_A: ca = v;
                CFG_SIN_A: sa = v;
                CFG_COS_B: cb = v;
                CFG_SIN_B: sb = v;
                CFG_SCALE: k1 = v;
                default: ;
            endcase
        endfunction

        function longint mq(longint a, longint b);
            return (a * b) / 16384;
        endfunction

        function logic [6:0] glyph_of(int n);
            string s;
            s = ".,-~:;=!*#$@";
            return 7'(s[n]);
        endfunction

        function void note_input(logic md, logic signed [15:0] cth, logic signed [15:0] sth,
                                 logic signed [15:0] cph, logic signed [15:0] sph,
                                 logic [5:0] row, logic [5:0] col);
            shade_res_t r;
            longint ct, st, cp, sp, a, b, c, d, circ, x, y, z, ooz, xp, yp, lum, idx;
            int cidx;
            r.glyph = BLANK_CHAR; r.drawn = 0; r.off = 0;
            if (md == MODE_READ) begin
                if (row < H && col < W) begin
                    cidx = row * W + col;
                    r.glyph = (code[cidx] == 0 || code[cidx] > 12) ? BLANK_CHAR
                              : glyph_of(code[cidx] - 1);
                    code[cidx] = 0;
                    zdep[cidx] = 0;
                end
                pending.push_back(r);
                return;
            end
            ct = cth; st = sth; cp = cph; sp = sph;
            a = ca; b = sa; c = cb; d = sb;
            circ = 32768 + ct;
            x = mq(circ, mq(c, cp) + mq(mq(b, d), sp)) - mq(mq(a, d), st);
            y = mq(circ, mq(cp, d) - mq(mq(c, b), sp)) + mq(mq(a, c), st);
            z = 5 * 16384 + mq(a, mq(circ, sp)) + mq(b, st);
            if (z <= 0) begin
                r.off = 1;
                pending.push_back(r);
                return;
            end
            ooz = (longint'(1) << 30) / z;
            if (ooz > 65535) ooz = 65535;
            xp = ((longint'(W / 2) << 38) + longint'(k1) * ooz * x) / (longint'(1) << 38);
            yp = ((longint'(H / 2) << 39) - longint'(k1) * ooz * y) / (longint'(1) << 39);
            if (xp < 0 || xp >= W || yp < 0 || yp >= H) begin
                r.off = 1;
                pending.push_back(r);
                return;
            end
            lum = mq(mq(cp, ct), d) - mq(mq(a, ct), sp) - mq(b, st)
                + mq(c, mq(a, st) - mq(mq(ct, b), sp));
            cidx = int'(yp * W + xp);
            if (lum > 0 && ooz > zdep[cidx]) begin
                idx = (lum * 8) / 16384;
                if (idx > 11) idx = 11;
                zdep[cidx] = 16'(ooz);
                code[cidx] = 4'(idx + 1);
                r.glyph = glyph_of(int'(idx));
                r.drawn = 1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [6:0] g, logic dr, logic off);
            shade_res_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result glyph=%0d", g);
                return;
            end
            e = pending.pop_front();
            if (e.glyph !== g || e.drawn !== dr || e.off !== off) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: exp g=%0d d=%0b o=%0b got g=%0d d=%0b o=%0b",
                             checked, e.glyph, e.drawn, e.off, g, dr, off);
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TRIG_W-1:0] cfg_data;
    logic s_valid, s_ready, s_mode;
    logic signed [TRIG_W-1:0] s_cos_theta, s_sin_theta, s_cos_phi, s_sin_phi;
    logic [5:0] s_cell_row, s_cell_col;
    logic m_valid, m_ready;
    logic [GLYPH_W-1:0] m_glyph;
    logic m_drawn, m_off_screen;

    torus_point_zbuffer_shader_top #(.SCREEN_WIDTH(W), .SCREEN_HEIGHT(H)) u_dut (.*);

    shade_board sb;
    longint cycles = 0;
    int hold_off = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int plots, reads;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("torus_point_zbuffer_shader_top_tb: done, errors");
            $finish;
        end
    end

    // receiver: stall pattern plus long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_glyph, m_drawn, m_off_screen);
            if (hold_req && !hold_taken) begin
                hold_taken <= 1;
                hold_off <= 3000;
                m_ready <= 0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 0;
            end else begin
                m_ready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic send_item(logic md, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d, logic [5:0] row, logic [5:0] col);
        s_valid <= 1;
        s_mode <= md;
        s_cos_theta <= a; s_sin_theta <= b; s_cos_phi <= c; s_sin_phi <= d;
        s_cell_row <= row; s_cell_col <= col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(md, a, b, c, d, row, col);
        if (md == MODE_READ) reads++; else plots++;
    endtask

    task automatic gap();
        s_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [15:0] trig_rand();
        int v;
        if ($urandom_range(0, 19) == 0) return 16'($urandom());
        v = $urandom_range(0, 32768);
        return 16'(v - 16384);
    endfunction

    task automatic random_burst(int n, int read_pct);
        int burst;
        real t, p;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                if ($urandom_range(0, 1)) gap();
                burst = $urandom_range(1, 20);
            end
            burst--;
            if ($urandom_range(0, 99) < read_pct) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(MODE_READ, trig_rand(), trig_rand(), trig_rand(), trig_rand(),
                              6'($urandom()), 6'($urandom()));
                else
                    send_item(MODE_READ, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                              16'($urandom()), 6'($urandom_range(0, H - 1)),
                              6'($urandom_range(0, W - 1)));
            end else if ($urandom_range(0, 3) != 0) begin
                // well-formed samples on the torus surface
                t = $urandom_range(0, 628) / 100.0;
                p = $urandom_range(0, 628) / 100.0;
                send_item(MODE_PLOT, 16'($rtoi($cos(t) * 16384)), 16'($rtoi($sin(t) * 16384)),
                          16'($rtoi($cos(p) * 16384)), 16'($rtoi($sin(p) * 16384)),
                          6'($urandom()), 6'($urandom()));
            end else begin
                send_item(MODE_PLOT, trig_rand(), trig_rand(), trig_rand(), trig_rand(),
                          6'($urandom()), 6'($urandom()));
            end
        end
    endtask

    task automatic set_angles(real a, real b, logic [15:0] k);
        write_reg(CFG_COS_A, 16'($rtoi($cos(a) * 16384)));
        write_reg(CFG_SIN_A, 16'($rtoi($sin(a) * 16384)));
        write_reg(CFG_COS_B, 16'($rtoi($cos(b) * 16384)));
        write_reg(CFG_SIN_B, 16'($rtoi($sin(b) * 16384)));
        write_reg(CFG_SCALE, k);
    endtask

    initial begin
        sb = new();
        plots = 0; reads = 0;
        aresetn = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        s_valid = 0; s_mode = 0;
        s_cos_theta = 0; s_sin_theta = 0; s_cos_phi = 0; s_sin_phi = 0;
        s_cell_row = 0; s_cell_col = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: default config
        send_item(MODE_PLOT, 16384, 0, 16384, 0, 0, 0);
        send_item(MODE_PLOT, 16384, 0, 16384, 0, 0, 0);
        send_item(MODE_PLOT, -16384, 0, 0, 16384, 0, 0);
        send_item(MODE_PLOT, 0, 16384, -16384, 0, 0, 0);
        send_item(MODE_PLOT, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0);
        send_item(MODE_PLOT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 63, 63);
        send_item(MODE_PLOT, 16384, 16384, 0, -16384, 0, 0);
        send_item(MODE_PLOT, 11585, 11585, 11585, -11585, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 25, 25);
        send_item(MODE_READ, 0, 0, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 49, 49);
        send_item(MODE_READ, 0, 0, 0, 0, 50, 10);
        send_item(MODE_READ, 0, 0, 0, 0, 10, 63);
        drain();

        set_angles(1.0, 0.5, 16'd8000);
        random_burst(150, 15);
        drain();
        write_reg(CFG_SCALE, 16'hFFFF);
        write_reg(CFG_SIN_A, -16384);
        write_reg(CFG_COS_A, 0);
        send_item(MODE_PLOT, 16384, 0, 16384, 0, 0, 0);
        random_burst(60, 10);
        drain();
        write_reg(CFG_SCALE, 0);
        write_reg(CFG_COS_B, -16384);
        write_reg(CFG_SIN_B, 16384);
        random_burst(40, 10);
        drain();
        write_reg(CFG_COS_A, 16'h7FFF);
        write_reg(CFG_SIN_A, 16'h8000);
        random_burst(40, 10);
        drain();

        set_angles(2.3, 4.1, 16'd12000);
        hold_req = 1'b1;
        random_burst(200, 20);
        drain();
        set_angles(5.5, 1.7, 16'd4000);
        random_burst(250, 20);
        drain();
        set_angles(0.3, 3.0, 16'd8000);
        random_burst(250, 25);
        for (int r = 0; r < 8; r++)
            send_item(MODE_READ, 0, 0, 0, 0, 6'($urandom_range(0, H - 1)),
                      6'($urandom_range(0, W - 1)));
        drain();

        $display("covered %0d plot and %0d read transactions over several settings",
                 plots, reads);
        if (sb.errors == 0) begin
            $display("torus_point_zbuffer_shader_top_tb: done, clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("torus_point_zbuffer_shader_top_tb: done, errors");
        end
        $finish;
    end
endmodule
